### hdl/sal_pkg.sv
// Package for the shifting array list: operation and status codes, the per-cell
// command code and the control bundle broadcast to every element cell. No dependencies.
package sal_pkg;

  localparam int CTRL_W = 11;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_INSERT  = 3'd2,
    OP_OREMOVE = 3'd3,
    OP_UREMOVE = 3'd4,
    OP_READ    = 3'd5,
    OP_WRITE   = 3'd6,
    OP_CLEAR   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_NOP     = 3'd0,
    CELL_PUSH    = 3'd1,
    CELL_POP     = 3'd2,
    CELL_INSERT  = 3'd3,
    CELL_OREMOVE = 3'd4,
    CELL_UREMOVE = 3'd5,
    CELL_WRITE   = 3'd6
  } cell_op_t;

  // Index and count fields are wide enough for the largest supported capacity.
  typedef struct packed {
    cell_op_t            op;
    logic [CTRL_W-1:0]   pos;
    logic [CTRL_W-1:0]   cnt;
  } cell_ctrl_t;

endpackage

### hdl/sal_cell.sv
// One element cell of the shifting array list: holds one word and takes its next
// value from the broadcast command or from a neighbor. Depends on sal_pkg.
module sal_cell
  import sal_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic signed [31:0] data_word,
  input  logic signed [31:0] last_word,
  input  logic signed [31:0] left_word,
  input  logic signed [31:0] right_word,
  output logic signed [31:0] value,
  output logic signed [31:0] sel_word,
  output logic signed [31:0] tail_word
);

  localparam logic [CTRL_W-1:0] ME     = CTRL_W'(IDX);
  localparam logic [CTRL_W-1:0] ME_INC = CTRL_W'(IDX + 1);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      CELL_PUSH: begin
        if (ME == ctrl.cnt) value_nxt = data_word;
      end
      CELL_POP: begin
        if (ME_INC == ctrl.cnt) value_nxt = '0;
      end
      CELL_INSERT: begin
        if (ME == ctrl.pos) value_nxt = data_word;
        else if (ME > ctrl.pos && ME <= ctrl.cnt) value_nxt = left_word;
      end
      CELL_OREMOVE: begin
        if (ME >= ctrl.pos && ME_INC < ctrl.cnt) value_nxt = right_word;
      end
      CELL_UREMOVE: begin
        if (ME_INC == ctrl.cnt) value_nxt = '0;
        else if (ME == ctrl.pos) value_nxt = last_word;
      end
      CELL_WRITE: begin
        if (ME == ctrl.pos) value_nxt = data_word;
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign value     = value_r;
  assign sel_word  = (ME == ctrl.pos) ? value_r : '0;
  assign tail_word = (ME_INC == ctrl.cnt) ? value_r : '0;

endmodule

### hdl/shifting_array_list.sv
// Shifting array list: a chain of element cells with a count and status logic.
// The result strobe is registered and comes in the cycle after a command is transferred.
// Throughput: one command per cycle; each affected cell shifts or loads in that same cycle.
// Reset (synchronous, active low) zeroes every cell and the count; no clearing pass.
// The result is held for one cycle only, as the receiver cannot stall.
module shifting_array_list
  import sal_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_operation,
  input  logic [5:0]                       in_position,
  input  logic signed [31:0]               in_data_word,
  output logic                             out_valid,
  output logic signed [31:0]               out_read_word,
  output logic [$clog2(CAPACITY + 1)-1:0]  out_element_count,
  output logic [1:0]                       out_status
);

  localparam int                CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CTRL_W-1:0] CAP_C = CTRL_W'(CAPACITY);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               valid_r;
  logic signed [31:0] read_r, read_nxt;
  status_t            status_r, status_nxt;

  cell_ctrl_t         ctrl;
  logic [CTRL_W-1:0]  pos_c, cnt_c;
  logic               accept;
  logic signed [31:0] sel_any, tail_any;

  logic signed [31:0] cell_value [CAPACITY];
  logic signed [31:0] cell_sel   [CAPACITY];
  logic signed [31:0] cell_tail  [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_c  = CTRL_W'(in_position);
  assign cnt_c  = CTRL_W'(cnt_r);

  always_comb begin
    sel_any  = '0;
    tail_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_any  = sel_any | cell_sel[i];
      tail_any = tail_any | cell_tail[i];
    end
  end

  always_comb begin
    ctrl.op    = CELL_NOP;
    ctrl.pos   = pos_c;
    ctrl.cnt   = cnt_c;
    cnt_nxt    = cnt_r;
    read_nxt   = '0;
    status_nxt = ST_OK;
    if (accept) begin
      case (op_t'(in_operation))
        OP_PUSH: begin
          if (cnt_c == CAP_C) status_nxt = ST_FULL;
          else begin
            ctrl.op = CELL_PUSH;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        OP_POP: begin
          if (cnt_c == '0) status_nxt = ST_EMPTY;
          else begin
            ctrl.op = CELL_POP;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        OP_INSERT: begin
          if (cnt_c == CAP_C) status_nxt = ST_FULL;
          else if (pos_c > cnt_c) status_nxt = ST_BADIDX;
          else begin
            ctrl.op = CELL_INSERT;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        OP_OREMOVE, OP_UREMOVE: begin
          if (cnt_c == '0) status_nxt = ST_EMPTY;
          else if (pos_c >= cnt_c) status_nxt = ST_BADIDX;
          else begin
            ctrl.op = (op_t'(in_operation) == OP_OREMOVE) ? CELL_OREMOVE : CELL_UREMOVE;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        OP_READ: begin
          if (pos_c >= cnt_c) status_nxt = ST_BADIDX;
          else read_nxt = sel_any;
        end
        OP_WRITE: begin
          if (pos_c >= CAP_C) status_nxt = ST_BADIDX;
          else begin
            ctrl.op = CELL_WRITE;
            if (pos_c >= cnt_c) cnt_nxt = CNT_W'(pos_c + 1'b1);
          end
        end
        OP_CLEAR: cnt_nxt = '0;
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_value[g+1];
    end
    sal_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .data_word  (in_data_word),
      .last_word  (tail_any),
      .left_word  (left_w),
      .right_word (right_w),
      .value      (cell_value[g]),
      .sel_word   (cell_sel[g]),
      .tail_word  (cell_tail[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    read_r   <= read_nxt;
    status_r <= status_nxt;
  end

  assign out_valid         = valid_r;
  assign out_read_word     = read_r;
  assign out_element_count = cnt_r;
  assign out_status        = status_r;

endmodule

### test/shifting_array_list_tb.sv
// Self-checking testbench for shifting_array_list: directed and random list commands,
// each result checked against a behavioral model of the list kept in the bench.
// Depends on sal_pkg for the operation and status codes.
`timescale 1ns / 1ps

module shifting_array_list_tb;
  import sal_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_CMDS = 550;

  typedef struct {
    op_t         op;
    logic [31:0] read_word;
    logic [6:0]  count;
    status_t     status;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_operation;
  logic [5:0] in_position;
  logic signed [31:0] in_data_word;
  logic out_valid;
  logic signed [31:0] out_read_word;
  logic [6:0] out_element_count;
  logic [1:0] out_status;

  logic [31:0] list_store [LIST_DEPTH];
  int list_len;
  list_result_t expected_results [$];
  int mismatches;
  int commands_sent;
  int results_checked;
  int op_seen [8];
  int status_seen [4];
  bit no_idle;

  shifting_array_list u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_data_word      (in_data_word),
    .out_valid         (out_valid),
    .out_read_word     (out_read_word),
    .out_element_count (out_element_count),
    .out_status        (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one command to the bench copy of the list and returns the result it must give.
  function automatic list_result_t apply_command(op_t op, logic [5:0] pos, logic [31:0] data);
    list_result_t res;
    int p;
    p = int'(pos);
    res.op = op;
    res.read_word = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_store[list_len] = data;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          list_store[list_len - 1] = '0;
          list_len--;
        end
      end
      OP_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (p > list_len) begin
          res.status = ST_BADIDX;
        end else begin
          for (int i = list_len; i > p; i--) list_store[i] = list_store[i - 1];
          list_store[p] = data;
          list_len++;
        end
      end
      OP_OREMOVE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= list_len) begin
          res.status = ST_BADIDX;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_store[i] = list_store[i + 1];
          list_len--;
        end
      end
      OP_UREMOVE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= list_len) begin
          res.status = ST_BADIDX;
        end else begin
          list_store[p] = list_store[list_len - 1];
          list_store[list_len - 1] = '0;
          list_len--;
        end
      end
      OP_READ: begin
        if (p >= list_len) res.status = ST_BADIDX;
        else res.read_word = list_store[p];
      end
      OP_WRITE: begin
        list_store[p] = data;
        if (p + 1 > list_len) list_len = p + 1;
      end
      default: begin
        list_len = 0;
      end
    endcase
    res.count = list_len[6:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_cycles(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_command(op_t op, logic [5:0] pos, logic [31:0] data);
    list_result_t res;
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_data_word <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = apply_command(op, pos, data);
    expected_results.push_back(res);
    commands_sent++;
    op_seen[op]++;
    status_seen[res.status]++;
    idle_cycles(pick_gap());
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    list_result_t res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        res = expected_results.pop_front();
        results_checked++;
        if (out_read_word !== res.read_word)
          report_mismatch($sformatf("%s read_word got %h expected %h",
                                    res.op.name(), out_read_word, res.read_word));
        if (out_element_count !== res.count)
          report_mismatch($sformatf("%s element_count got %0d expected %0d",
                                    res.op.name(), out_element_count, res.count));
        if (out_status !== res.status)
          report_mismatch($sformatf("%s status got %0d expected %s",
                                    res.op.name(), out_status, res.status.name()));
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stalled = 0;
      else stalled++;
    end
    $display("shifting_array_list test failed");
    $finish;
  end

  task automatic test_empty_list();
    send_command(OP_READ, 6'd0, 32'h0);
    send_command(OP_POP, 6'd0, 32'h0);
    send_command(OP_OREMOVE, 6'd0, 32'h0);
    send_command(OP_UREMOVE, 6'd63, 32'h0);
    send_command(OP_INSERT, 6'd1, 32'h1111_1111);
  endtask

  task automatic test_shifting();
    send_command(OP_PUSH, 6'd0, 32'h7FFF_FFFF);
    send_command(OP_PUSH, 6'd0, 32'h8000_0000);
    send_command(OP_INSERT, 6'd0, 32'hFFFF_FFFF);
    send_command(OP_INSERT, 6'd3, 32'h1234_5678);
    send_command(OP_INSERT, 6'd5, 32'hDEAD_BEEF);
    send_command(OP_OREMOVE, 6'd1, 32'h0);
    send_command(OP_OREMOVE, 6'd3, 32'h0);
    send_command(OP_UREMOVE, 6'd0, 32'h0);
    send_command(OP_UREMOVE, 6'd1, 32'h0);
    send_command(OP_READ, 6'd0, 32'h0);
  endtask

  // Ordered remove and clear both leave old words in the store; writes past the count
  // bring them back into view.
  task automatic test_exposed_slots();
    send_command(OP_WRITE, 6'd4, 32'hA5A5_5A5A);
    send_command(OP_READ, 6'd3, 32'h0);
    send_command(OP_CLEAR, 6'd0, 32'h0);
    send_command(OP_READ, 6'd0, 32'h0);
    send_command(OP_WRITE, 6'd1, 32'h0F0F_F0F0);
    send_command(OP_READ, 6'd0, 32'h0);
  endtask

  task automatic test_full_list();
    send_command(OP_WRITE, 6'd63, 32'h8000_0001);
    send_command(OP_PUSH, 6'd0, 32'h5555_5555);
    send_command(OP_INSERT, 6'd0, 32'hAAAA_AAAA);
    send_command(OP_READ, 6'd63, 32'h0);
    send_command(OP_POP, 6'd0, 32'h0);
    send_command(OP_UREMOVE, 6'd63, 32'h0);
  endtask

  task automatic test_random(int n_cmds);
    int target;
    int r;
    op_t op;
    logic [5:0] pos;
    target = 32;
    for (int i = 0; i < n_cmds; i++) begin
      if (i % 40 == 0) target = $urandom_range(0, LIST_DEPTH);
      no_idle = ((i / 60) % 4 == 2);
      r = $urandom_range(0, 99);
      if (list_len < target) begin
        if (r < 30) op = OP_PUSH;
        else if (r < 55) op = OP_INSERT;
        else if (r < 65) op = OP_WRITE;
        else if (r < 75) op = OP_READ;
        else if (r < 83) op = OP_OREMOVE;
        else if (r < 90) op = OP_UREMOVE;
        else if (r < 98) op = OP_POP;
        else op = OP_CLEAR;
      end else begin
        if (r < 22) op = OP_POP;
        else if (r < 42) op = OP_OREMOVE;
        else if (r < 62) op = OP_UREMOVE;
        else if (r < 77) op = OP_READ;
        else if (r < 85) op = OP_WRITE;
        else if (r < 92) op = OP_PUSH;
        else if (r < 97) op = OP_INSERT;
        else op = OP_CLEAR;
      end
      if ($urandom_range(0, 99) < 15) begin
        pos = 6'($urandom_range(0, 63));
      end else if (op == OP_INSERT) begin
        pos = 6'($urandom_range(0, list_len));
      end else if (op == OP_WRITE) begin
        pos = 6'($urandom_range(0, (list_len + 4 > 63) ? 63 : list_len + 4));
      end else begin
        pos = (list_len == 0) ? 6'd0 : 6'($urandom_range(0, list_len - 1));
      end
      send_command(op, pos, pick_word());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_PUSH;
    in_position = '0;
    in_data_word = '0;
    mismatches = 0;
    commands_sent = 0;
    results_checked = 0;
    no_idle = 1'b0;
    list_len = 0;
    foreach (list_store[i]) list_store[i] = '0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_shifting();
    test_exposed_slots();
    test_full_list();
    test_random(RANDOM_CMDS);

    idle_cycles(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d results for %0d commands; push %0d, pop %0d, insert %0d, ",
             results_checked, commands_sent, op_seen[OP_PUSH], op_seen[OP_POP],
             op_seen[OP_INSERT]);
    $display("removes %0d/%0d, reads %0d, writes %0d, clears %0d; full %0d, empty %0d, bad %0d.",
             op_seen[OP_OREMOVE], op_seen[OP_UREMOVE], op_seen[OP_READ], op_seen[OP_WRITE],
             op_seen[OP_CLEAR], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BADIDX]);
    if (mismatches == 0) begin
      $display("shifting_array_list test passed");
    end else begin
      $display("shifting_array_list test failed");
    end
    $finish;
  end

endmodule
